### rtl/pfma_pkg.sv
// ---------------------------------------------------------------------------
// pfma_pkg
// Shared constants for the prime-field modular ALU: opcodes, modulus
// register width and reset value, default parameter values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfma_pkg;

	// modulus register
	localparam int MOD_BITS = 16;
	localparam logic [MOD_BITS-1:0] MOD_RESET = 16'd65521;

	// parameter defaults
	localparam int ELEMENT_BITS_DEF  = 16;
	localparam int EXPONENT_BITS_DEF = 32;

	// opcodes
	localparam int OP_BITS = 3;
	localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
	localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
	localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
	localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
	localparam logic [OP_BITS-1:0] OP_INV = 3'd4;
	localparam logic [OP_BITS-1:0] OP_POW = 3'd5;
	localparam logic [OP_BITS-1:0] OP_NEG = 3'd6;
	localparam logic [OP_BITS-1:0] OP_EQU = 3'd7;

endpackage

### rtl/prime_field_modular_alu.sv
// ---------------------------------------------------------------------------
// prime_field_modular_alu
// GF(p) arithmetic unit: add, sub, mul, div, inverse, power, negate, equal,
// built round one restoring divider and one 17x17 multiplier.
// ---------------------------------------------------------------------------
//  channel  | signals                               | dir
//  ---------+---------------------------------------+-----
//  in       | in_valid in_ready opcode operand_a/b  | in
//           | exponent                              |
//  out      | out_valid out_ready result_value      | out
//  cfg      | cfg_we cfg_wdata (modulus)            | in
//
// Every beat first reduces both operands through the bit-serial divider
// (DW = 34 bits wide at default widths); sub/neg/equal need no further
// pass, add takes a third divider pass and mul a multiply and a third pass.
// Each Euclid step of inverse and divide is a full divider pass and a
// multiply; divide ends with a further multiply-and-reduce pass.
// Power costs up to two multiply-and-reduce passes per exponent bit.
// in_ready is high only while the sequencer is idle; a finished result may
// wait in the output register while the next beat is taken. Reset clears
// the sequencer and sets the modulus to 65521.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_field_modular_alu
	import pfma_pkg::*;
#(
	parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF,
	parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [MOD_BITS-1:0]      cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_BITS-1:0]       opcode,
	input  logic [ELEMENT_BITS-1:0]  operand_a,
	input  logic [ELEMENT_BITS-1:0]  operand_b,
	input  logic [EXPONENT_BITS-1:0] exponent,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ELEMENT_BITS-1:0]  result_value
);

	localparam int MB = MOD_BITS;
	localparam int MW = MB + 1;
	localparam int PW = 2 * MW;
	localparam int SW = MB + 2;
	localparam int DW = (ELEMENT_BITS + 1 > PW) ? ELEMENT_BITS + 1 : PW;
	localparam int CW = $clog2(DW + 1);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIV   = 4'd1;
	localparam logic [3:0] S_AM    = 4'd2;
	localparam logic [3:0] S_BM    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_EU    = 4'd5;
	localparam logic [3:0] S_EUQ   = 4'd6;
	localparam logic [3:0] S_EUM   = 4'd7;
	localparam logic [3:0] S_EUS   = 4'd8;
	localparam logic [3:0] S_INVD  = 4'd9;
	localparam logic [3:0] S_PW    = 4'd10;
	localparam logic [3:0] S_PACC  = 4'd11;
	localparam logic [3:0] S_PSQ   = 4'd12;
	localparam logic [3:0] S_PBASE = 4'd13;
	localparam logic [3:0] S_RES   = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	logic [3:0]               state_q, ret_q, mret_q;
	logic [MB-1:0]            modulus_q, p_q;
	logic [OP_BITS-1:0]       op_q;
	logic [ELEMENT_BITS-1:0]  a_q, b_q;
	logic [EXPONENT_BITS-1:0] e_q;
	logic [MB-1:0]            am_q, bm_q, acc_q, base_q, val_q;
	logic [MB-1:0]            r0_q, r1_q;
	logic signed [SW-1:0]     s0_q, s1_q;
	logic [MW-1:0]            mx_q, my_q;
	logic [PW-1:0]            prod_q;
	logic                     out_valid_q;
	logic [ELEMENT_BITS-1:0]  result_q;

	// divider registers
	logic [DW-1:0]            num_q;
	logic [MB-1:0]            rem_q, den_q;
	logic [CW-1:0]            cnt_q;

	// divider step
	logic [MB:0]              dv_t;
	logic                     dv_ge;
	logic [MB-1:0]            dv_rem;
	assign dv_t   = {rem_q, num_q[DW-1]};
	assign dv_ge  = dv_t >= {1'b0, den_q};
	assign dv_rem = dv_ge ? MB'(dv_t - {1'b0, den_q}) : dv_t[MB-1:0];

	// shared multiplier
	logic [PW-1:0]            mul_p;
	assign mul_p = mx_q * my_q;

	// Euclid helpers
	logic [MW-1:0]            s1_mag;
	logic signed [PW:0]       s_new;
	logic signed [SW-1:0]     inv_s;
	assign s1_mag = s1_q[SW-1] ? MW'(-s1_q) : MW'(s1_q);
	assign s_new  = s1_q[SW-1] ? (PW+1)'(s0_q) + $signed({1'b0, prod_q})
	                           : (PW+1)'(s0_q) - $signed({1'b0, prod_q});
	assign inv_s  = s0_q[SW-1] ? s0_q + $signed({2'b00, p_q}) : s0_q;

	// direct results from the reduced operands
	logic [MB-1:0]            sub_r, neg_r;
	assign sub_r  = (am_q >= bm_q) ? am_q - bm_q : MB'({1'b0, am_q} + {1'b0, p_q} - {1'b0, bm_q});
	assign neg_r  = (a_q == '0) ? '0 : p_q - am_q;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = result_q;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// output beat: load a new result or drop the taken one
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						a_q     <= operand_a;
						b_q     <= operand_b;
						e_q     <= exponent;
						p_q     <= (modulus_q == '0) ? MB'(1) : modulus_q;
						num_q   <= DW'(operand_a);
						rem_q   <= '0;
						den_q   <= (modulus_q == '0) ? MB'(1) : modulus_q;
						cnt_q   <= CW'(DW);
						ret_q   <= S_AM;
						state_q <= S_DIV;
					end
				end
				// one quotient bit per cycle
				S_DIV: begin
					num_q <= {num_q[DW-2:0], dv_ge};
					rem_q <= dv_rem;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ret_q;
					end
				end
				S_AM: begin
					am_q    <= rem_q;
					num_q   <= DW'(b_q);
					rem_q   <= '0;
					den_q   <= p_q;
					cnt_q   <= CW'(DW);
					ret_q   <= S_BM;
					state_q <= S_DIV;
				end
				// dispatch on opcode
				S_BM: begin
					bm_q <= rem_q;
					case (op_q)
						OP_ADD: begin
							num_q   <= DW'({1'b0, am_q} + {1'b0, rem_q});
							rem_q   <= '0;
							den_q   <= p_q;
							cnt_q   <= CW'(DW);
							ret_q   <= S_RES;
							state_q <= S_DIV;
						end
						OP_SUB, OP_NEG, OP_EQU: begin
							state_q <= S_RES;
							ret_q   <= S_OUT;
						end
						OP_MUL: begin
							mx_q    <= MW'(am_q);
							my_q    <= MW'(rem_q);
							mret_q  <= S_RES;
							state_q <= S_MUL;
						end
						OP_DIV, OP_INV: begin
							r0_q <= (op_q == OP_DIV) ? rem_q : am_q;
							r1_q <= p_q;
							s0_q <= SW'(1);
							s1_q <= '0;
							if ((op_q == OP_DIV && (b_q == '0 || rem_q == '0)) ||
							    (op_q == OP_INV && am_q == '0)) begin
								val_q   <= '0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_EU;
							end
						end
						default: begin
							acc_q  <= MB'(1);
							base_q <= am_q;
							if (e_q == '0) begin
								val_q   <= MB'(1);
								state_q <= S_OUT;
							end else if (a_q == '0) begin
								val_q   <= '0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_PW;
							end
						end
					endcase
				end
				// product into the divider
				S_MUL: begin
					num_q   <= DW'(mul_p);
					rem_q   <= '0;
					den_q   <= p_q;
					cnt_q   <= CW'(DW);
					ret_q   <= mret_q;
					state_q <= S_DIV;
				end
				// extended Euclid: q = r0 / r1
				S_EU: begin
					if (r1_q == '0) begin
						state_q <= S_INVD;
					end else begin
						num_q   <= DW'(r0_q);
						rem_q   <= '0;
						den_q   <= r1_q;
						cnt_q   <= CW'(DW);
						ret_q   <= S_EUQ;
						state_q <= S_DIV;
					end
				end
				S_EUQ: begin
					r0_q    <= r1_q;
					r1_q    <= rem_q;
					mx_q    <= MW'(num_q[MB-1:0]);
					my_q    <= s1_mag;
					state_q <= S_EUM;
				end
				S_EUM: begin
					prod_q  <= mul_p;
					state_q <= S_EUS;
				end
				S_EUS: begin
					s0_q    <= s1_q;
					s1_q    <= s_new[SW-1:0];
					state_q <= S_EU;
				end
				S_INVD: begin
					if (op_q == OP_INV) begin
						val_q   <= inv_s[MB-1:0];
						state_q <= S_OUT;
					end else begin
						mx_q    <= MW'(am_q);
						my_q    <= MW'(inv_s[MB-1:0]);
						mret_q  <= S_RES;
						state_q <= S_MUL;
					end
				end
				// square-and-multiply, LSB first
				S_PW: begin
					if (e_q == '0) begin
						val_q   <= acc_q;
						state_q <= S_OUT;
					end else if (e_q[0]) begin
						mx_q    <= MW'(acc_q);
						my_q    <= MW'(base_q);
						mret_q  <= S_PACC;
						state_q <= S_MUL;
					end else begin
						state_q <= S_PSQ;
					end
				end
				S_PACC: begin
					acc_q   <= rem_q;
					state_q <= S_PSQ;
				end
				S_PSQ: begin
					if ((e_q >> 1) == '0) begin
						e_q     <= '0;
						state_q <= S_PW;
					end else begin
						mx_q    <= MW'(base_q);
						my_q    <= MW'(base_q);
						mret_q  <= S_PBASE;
						state_q <= S_MUL;
					end
				end
				S_PBASE: begin
					base_q  <= rem_q;
					e_q     <= e_q >> 1;
					state_q <= S_PW;
				end
				// pick the result
				S_RES: begin
					case (op_q)
						OP_SUB:  val_q <= sub_r;
						OP_NEG:  val_q <= neg_r;
						OP_EQU:  val_q <= (am_q == bm_q) ? MB'(1) : '0;
						default: val_q <= rem_q;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						result_q    <= ELEMENT_BITS'(val_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/pfma_checker.sv
// ---------------------------------------------------------------------------
// pfma_checker
// Port-level checks on the modular ALU handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfma_checker
	import pfma_pkg::*;
#(
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [ELEMENT_BITS-1:0] result_value
);

	// busy after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after accept");

	// no new result in the cycle after accept while the output register is free
	a_no_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
		else $error("result appeared one cycle after accept");

	// a new result only comes out of a busy sequencer
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("stalled result changed");

endmodule

bind prime_field_modular_alu pfma_checker #(.ELEMENT_BITS(ELEMENT_BITS)) u_pfma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value)
);
